// ===== design/psra_pkg.sv =====
// ----------------------------------------------------------------------------
// psra_pkg
// Shared codes and types for the palette slot allocator: request codes,
// result status codes and the write enable group between control and store.
// ----------------------------------------------------------------------------
package psra_pkg;

    localparam int COLOR_W = 24;
    localparam int OUT_CNT_W = 16;

    localparam logic [2:0] FN_ADD     = 3'd0;
    localparam logic [2:0] FN_RELEASE = 3'd1;
    localparam logic [2:0] FN_BLOCK   = 3'd2;
    localparam logic [2:0] FN_CLEAR   = 3'd3;
    localparam logic [2:0] FN_WRITE   = 3'd4;

    localparam logic [2:0] ST_MATCH  = 3'd0;
    localparam logic [2:0] ST_NEW    = 3'd1;
    localparam logic [2:0] ST_FULL   = 3'd2;
    localparam logic [2:0] ST_UNUSED = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    typedef struct packed {
        logic color;
        logic uses;
    } t_wr_en;

endpackage

// ===== design/psra_store.sv =====
// ----------------------------------------------------------------------------
// psra_store
// Entry store: one memory of colors and one of usage counts, sharing a read
// address and a write address, with registered read data.
// ----------------------------------------------------------------------------
module psra_store import psra_pkg::*; #(
    parameter int ENTRIES = 256,
    parameter int COUNT_BITS = 16,
    localparam int IW = $clog2(ENTRIES)
) (
    input  logic                         i_clk,
    input  logic [IW-1:0]                i_rd_addr,
    input  logic [IW-1:0]                i_wr_addr,
    input  t_wr_en                       i_wr_en,
    input  logic [COLOR_W-1:0]           i_wr_color,
    input  logic signed [COUNT_BITS-1:0] i_wr_uses,
    output logic [COLOR_W-1:0]           o_rd_color,
    output logic signed [COUNT_BITS-1:0] o_rd_uses
);

    logic [COLOR_W-1:0]           r_color [ENTRIES];
    logic signed [COUNT_BITS-1:0] r_uses  [ENTRIES];
    logic [COLOR_W-1:0]           r_rd_color;
    logic signed [COUNT_BITS-1:0] r_rd_uses;

    always_ff @(posedge i_clk) begin
        if (i_wr_en.color) begin
            r_color[i_wr_addr] <= i_wr_color;
        end
        r_rd_color <= r_color[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en.uses) begin
            r_uses[i_wr_addr] <= i_wr_uses;
        end
        r_rd_uses <= r_uses[i_rd_addr];
    end

    assign o_rd_color = r_rd_color;
    assign o_rd_uses  = r_rd_uses;

endmodule

// ===== design/psra_ctrl.sv =====
// ----------------------------------------------------------------------------
// psra_ctrl
// Request sequencer: scans the store for add, reads one entry for release,
// write, block and unused codes, sweeps writes for block, clear and the
// power-up clear, and registers the result.
// ----------------------------------------------------------------------------
module psra_ctrl import psra_pkg::*; #(
    parameter int ENTRIES = 256,
    parameter int COUNT_BITS = 16,
    localparam int IW = $clog2(ENTRIES)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [2:0]                   i_func,
    input  logic [COLOR_W-1:0]           i_rgb,
    input  logic [7:0]                   i_slot,
    input  logic [8:0]                   i_span,
    output logic [IW-1:0]                o_rd_addr,
    output logic [IW-1:0]                o_wr_addr,
    output t_wr_en                       o_wr_en,
    output logic [COLOR_W-1:0]           o_wr_color,
    output logic signed [COUNT_BITS-1:0] o_wr_uses,
    input  logic [COLOR_W-1:0]           i_rd_color,
    input  logic signed [COUNT_BITS-1:0] i_rd_uses,
    output logic                         o_valid,
    output logic [7:0]                   o_slot_out,
    output logic [2:0]                   o_status,
    output logic signed [OUT_CNT_W-1:0]  o_use_count
);

    localparam int CW = (IW + 1 > 10) ? IW + 1 : 10;

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_LOOK  = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_SWEEP = 3'd5;

    localparam logic signed [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
    localparam logic signed [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);
    localparam logic signed [COUNT_BITS-1:0] CNT_BLK = '1;
    localparam logic [CW-1:0] END_ALL = CW'(ENTRIES);

    logic [2:0]                   r_state, n_state;
    logic [2:0]                   r_func, n_func;
    logic [COLOR_W-1:0]           r_rgb, n_rgb;
    logic [7:0]                   r_slot, n_slot;
    logic [8:0]                   r_span, n_span;
    logic [CW-1:0]                r_ptr, n_ptr;
    logic [CW-1:0]                r_end, n_end;
    logic                         r_rd_vld, n_rd_vld;
    logic [IW-1:0]                r_rd_idx, n_rd_idx;
    logic                         r_have_free, n_have_free;
    logic [IW-1:0]                r_free, n_free;
    logic signed [COUNT_BITS-1:0] r_fill, n_fill;
    logic signed [COUNT_BITS-1:0] r_cnt, n_cnt;
    logic                         r_valid, n_valid;
    logic [7:0]                   r_slot_out, n_slot_out;
    logic [2:0]                   r_status, n_status;
    logic signed [OUT_CNT_W-1:0]  r_use_count, n_use_count;

    logic                         slot_ok;
    logic                         in_use;
    logic                         hit;
    logic signed [COUNT_BITS-1:0] look_cnt;
    logic [CW-1:0]                blk_sum;
    logic [CW-1:0]                ptr_inc;

    function automatic logic signed [OUT_CNT_W-1:0] fmt_cnt(
        input logic signed [COUNT_BITS-1:0] c
    );
        logic signed [32:0] w;
        w = 33'(c);
        if (w > 33'sd32767) begin
            return 16'sd32767;
        end
        return w[OUT_CNT_W-1:0];
    endfunction

    assign slot_ok  = CW'(r_slot) < END_ALL;
    assign in_use   = !i_rd_uses[COUNT_BITS-1] && (i_rd_uses != '0);
    assign hit      = r_rd_vld && in_use && (i_rd_color == r_rgb);
    assign look_cnt = slot_ok ? i_rd_uses : '0;
    assign blk_sum  = CW'(r_slot) + CW'(r_span);
    assign ptr_inc  = r_ptr + CW'(1);

    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_rgb       = r_rgb;
        n_slot      = r_slot;
        n_span      = r_span;
        n_ptr       = r_ptr;
        n_end       = r_end;
        n_rd_vld    = r_rd_vld;
        n_rd_idx    = r_rd_idx;
        n_have_free = r_have_free;
        n_free      = r_free;
        n_fill      = r_fill;
        n_cnt       = r_cnt;
        n_valid     = 1'b0;
        n_slot_out  = r_slot_out;
        n_status    = r_status;
        n_use_count = r_use_count;
        o_wr_en     = '0;
        o_wr_addr   = r_ptr[IW-1:0];
        o_wr_color  = r_rgb;
        o_wr_uses   = r_fill;

        case (r_state)
            S_INIT: begin
                o_wr_en.color = 1'b1;
                o_wr_en.uses  = 1'b1;
                o_wr_color    = '0;
                o_wr_uses     = '0;
                n_ptr         = ptr_inc;
                if (ptr_inc == END_ALL) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_func      = i_func;
                    n_rgb       = i_rgb;
                    n_slot      = i_slot;
                    n_span      = i_span;
                    n_ptr       = CW'(i_slot);
                    n_rd_vld    = 1'b0;
                    n_have_free = 1'b0;
                    case (i_func)
                        FN_ADD: begin
                            n_ptr   = '0;
                            n_state = S_SCAN;
                        end
                        FN_CLEAR: begin
                            n_ptr   = '0;
                            n_end   = END_ALL;
                            n_fill  = '0;
                            n_cnt   = '0;
                            n_state = S_SWEEP;
                        end
                        default: begin
                            n_state = S_RD;
                        end
                    endcase
                end
            end
            S_RD: begin
                n_state = S_LOOK;
            end
            S_LOOK: begin
                n_state    = S_IDLE;
                n_valid    = 1'b1;
                n_slot_out = r_slot;
                n_status   = ST_DONE;
                n_use_count = fmt_cnt(look_cnt);
                case (r_func)
                    FN_RELEASE: begin
                        if (slot_ok && in_use) begin
                            o_wr_en.uses = 1'b1;
                            o_wr_uses    = i_rd_uses - CNT_ONE;
                            n_use_count  = fmt_cnt(i_rd_uses - CNT_ONE);
                        end else begin
                            n_status = ST_UNUSED;
                        end
                    end
                    FN_BLOCK: begin
                        if (slot_ok && (r_span != '0)) begin
                            n_valid = 1'b0;
                            n_end   = (blk_sum < END_ALL) ? blk_sum : END_ALL;
                            n_fill  = CNT_BLK;
                            n_cnt   = CNT_BLK;
                            n_state = S_SWEEP;
                        end
                    end
                    FN_WRITE: begin
                        o_wr_en.color = slot_ok;
                    end
                    default: begin
                    end
                endcase
            end
            S_SCAN: begin
                if (hit) begin
                    o_wr_en.uses = 1'b1;
                    o_wr_addr    = r_rd_idx;
                    o_wr_uses    = (i_rd_uses == CNT_MAX) ? i_rd_uses : i_rd_uses + CNT_ONE;
                    n_valid      = 1'b1;
                    n_slot_out   = 8'(r_rd_idx);
                    n_status     = ST_MATCH;
                    n_use_count  = fmt_cnt(o_wr_uses);
                    n_state      = S_IDLE;
                end else begin
                    if (r_rd_vld && !r_have_free && (i_rd_uses == '0)) begin
                        n_have_free = 1'b1;
                        n_free      = r_rd_idx;
                    end
                    if (r_ptr != END_ALL) begin
                        n_ptr    = ptr_inc;
                        n_rd_vld = 1'b1;
                        n_rd_idx = r_ptr[IW-1:0];
                    end else if (r_rd_vld) begin
                        n_rd_vld = 1'b0;
                    end else begin
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                        if (r_have_free) begin
                            o_wr_en.color = 1'b1;
                            o_wr_en.uses  = 1'b1;
                            o_wr_addr     = r_free;
                            o_wr_uses     = CNT_ONE;
                            n_slot_out    = 8'(r_free);
                            n_status      = ST_NEW;
                            n_use_count   = 16'sd1;
                        end else begin
                            n_slot_out  = '0;
                            n_status    = ST_FULL;
                            n_use_count = '0;
                        end
                    end
                end
            end
            S_SWEEP: begin
                o_wr_en.uses = 1'b1;
                n_ptr        = ptr_inc;
                if (ptr_inc == r_end) begin
                    n_valid     = 1'b1;
                    n_slot_out  = r_slot;
                    n_status    = ST_DONE;
                    n_use_count = fmt_cnt(r_cnt);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_ptr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func      <= n_func;
        r_rgb       <= n_rgb;
        r_slot      <= n_slot;
        r_span      <= n_span;
        r_end       <= n_end;
        r_rd_vld    <= n_rd_vld;
        r_rd_idx    <= n_rd_idx;
        r_have_free <= n_have_free;
        r_free      <= n_free;
        r_fill      <= n_fill;
        r_cnt       <= n_cnt;
        r_slot_out  <= n_slot_out;
        r_status    <= n_status;
        r_use_count <= n_use_count;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_rd_addr   = r_ptr[IW-1:0];
    assign o_valid     = r_valid;
    assign o_slot_out  = r_slot_out;
    assign o_status    = r_status;
    assign o_use_count = r_use_count;

    // A result strobe never repeats in the following cycle.
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid)
        else $error("result strobe held for two cycles");

    // An accepted request always leaves the idle state.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not start");

    // A count update during the scan is the match or new-entry result of this request.
    a_scan_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && o_wr_en.uses) |=> (r_valid &&
            (r_status == ST_MATCH || r_status == ST_NEW)))
        else $error("scan write without add result");

    // A newly allocated entry always starts with one user.
    a_new_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status == ST_NEW) |-> (r_use_count == 16'sd1))
        else $error("new entry count is not one");

    // A full store answers entry zero with a zero count.
    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status == ST_FULL) |-> (r_slot_out == '0 && r_use_count == '0))
        else $error("full result carries data");

endmodule

// ===== design/palette_slot_refcount_allocator_top.sv =====
// ----------------------------------------------------------------------------
// palette_slot_refcount_allocator_top
// Reference-counted palette allocator: a store of colors with usage counts.
//
// Requests are taken when start is high and busy is low. One request is
// worked on at a time; busy stays high until its result has been produced.
// Every request gives exactly one result, shown on o_slot_out, o_status and
// o_use_count for one cycle while o_valid is high. The receiver cannot stall.
// Work per request:
//   add: the scan reads one store entry per cycle and stops at a match;
//     a new entry or a full store is known once every entry has been read.
//   release, write entry, unused codes and an empty block: one entry read.
//   block range of n entries: one count write per cycle.
//   clear all: one count write per cycle over all entries.
// busy drops in the result cycle, so a new request can be taken there.
// After reset the block clears both memories, one entry per cycle, and
// holds busy high until the clear is done, before it takes the first request.
// ----------------------------------------------------------------------------
module palette_slot_refcount_allocator_top import psra_pkg::*; #(
    parameter int ENTRIES = 256,
    parameter int COUNT_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [2:0]                  i_func,
    input  logic [7:0]                  i_red,
    input  logic [7:0]                  i_green,
    input  logic [7:0]                  i_blue,
    input  logic [7:0]                  i_slot,
    input  logic [8:0]                  i_span,
    output logic                        o_valid,
    output logic [7:0]                  o_slot_out,
    output logic [2:0]                  o_status,
    output logic signed [OUT_CNT_W-1:0] o_use_count
);

    localparam int IW = $clog2(ENTRIES);

    logic [IW-1:0]                rd_addr;
    logic [IW-1:0]                wr_addr;
    t_wr_en                       wr_en;
    logic [COLOR_W-1:0]           wr_color;
    logic signed [COUNT_BITS-1:0] wr_uses;
    logic [COLOR_W-1:0]           rd_color;
    logic signed [COUNT_BITS-1:0] rd_uses;
    logic [COLOR_W-1:0]           rgb;

    assign rgb = {i_red, i_green, i_blue};

    psra_ctrl #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (COUNT_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_func      (i_func),
        .i_rgb       (rgb),
        .i_slot      (i_slot),
        .i_span      (i_span),
        .o_rd_addr   (rd_addr),
        .o_wr_addr   (wr_addr),
        .o_wr_en     (wr_en),
        .o_wr_color  (wr_color),
        .o_wr_uses   (wr_uses),
        .i_rd_color  (rd_color),
        .i_rd_uses   (rd_uses),
        .o_valid     (o_valid),
        .o_slot_out  (o_slot_out),
        .o_status    (o_status),
        .o_use_count (o_use_count)
    );

    psra_store #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (COUNT_BITS)
    ) u_store (
        .i_clk      (i_clk),
        .i_rd_addr  (rd_addr),
        .i_wr_addr  (wr_addr),
        .i_wr_en    (wr_en),
        .i_wr_color (wr_color),
        .i_wr_uses  (wr_uses),
        .o_rd_color (rd_color),
        .o_rd_uses  (rd_uses)
    );

endmodule
